// ===== rtl/core/omr_pkg.sv =====
// ----------------------------------------------------------------------------
// omr_pkg: shared types and constants of the bubble mark reader
// Count widths, density ratio constants, config codes and the cell record.
// ----------------------------------------------------------------------------
`default_nettype none

package omr_pkg;

  localparam int unsigned CountW     = 13;
  localparam int unsigned IdW        = 16;
  localparam int unsigned ChoiceW    = 4;
  localparam int unsigned PixelW     = 8;
  localparam int unsigned ProdW      = 2 * CountW;
  localparam int unsigned RatioW     = 17;
  localparam int unsigned IdCells    = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CountW-1:0]  CountMax        = '1;
  localparam logic [RatioW-1:0]  DensNum         = 17'd3;
  localparam logic [RatioW-1:0]  DensDen         = 17'd10;
  localparam logic [PixelW-1:0]  ThresholdReset  = 8'd200;
  localparam logic [ChoiceW-1:0] ChoicesReset    = 4'd4;

  typedef enum logic [1:0] {
    CfgThreshold = 2'd0,
    CfgChoices   = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    KindId     = 1'b0,
    KindAnswer = 1'b1
  } result_kind_e;

  // One finished cell as handed from the front to the back
  typedef struct packed {
    logic [CountW-1:0] dark;
    logic [CountW-1:0] total;
    logic              clr;
  } cell_rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/omr_front.sv =====
// ----------------------------------------------------------------------------
// omr_front: pixel classifier and cell counter
// Counts dark and total pixels of the current cell and emits a cell record.
// ----------------------------------------------------------------------------
`default_nettype none

module omr_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [omr_pkg::PixelW-1:0]  pixel_i,
  input  wire logic                        cell_end_i,
  input  wire logic                        sheet_start_i,
  input  wire logic [omr_pkg::PixelW-1:0]  threshold_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output omr_pkg::cell_rec_t               rec_o
);
  import omr_pkg::*;

  logic [CountW-1:0] dark_q, dark_d;
  logic [CountW-1:0] pix_q, pix_d;
  logic              clr_q, clr_d;
  logic              accept;
  logic [CountW-1:0] dark_nx, pix_nx, dark_base, pix_base;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    // A sheet start clears the counts before this pixel is counted
    dark_base = sheet_start_i ? '0 : dark_q;
    pix_base  = sheet_start_i ? '0 : pix_q;
    pix_nx    = (pix_base != CountMax) ? pix_base + 1'b1 : pix_base;
    dark_nx   = (pixel_i <= threshold_i && dark_base != CountMax) ? dark_base + 1'b1
                                                                   : dark_base;
    rec_o.dark  = dark_nx;
    rec_o.total = pix_nx;
    rec_o.clr   = clr_q || sheet_start_i;
    push_o      = accept && cell_end_i;
    dark_d      = dark_q;
    pix_d       = pix_q;
    clr_d       = clr_q;
    if (accept) begin
      if (cell_end_i) begin
        dark_d = '0;
        pix_d  = '0;
        clr_d  = 1'b0;
      end else begin
        dark_d = dark_nx;
        pix_d  = pix_nx;
        clr_d  = clr_q || sheet_start_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q <= '0;
      pix_q  <= '0;
      clr_q  <= 1'b0;
    end else begin
      dark_q <= dark_d;
      pix_q  <= pix_d;
      clr_q  <= clr_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/omr_queue.sv =====
// ----------------------------------------------------------------------------
// omr_queue: cell record queue
// Short FIFO that decouples the pixel front from the decision back.
// ----------------------------------------------------------------------------
`default_nettype none

module omr_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire omr_pkg::cell_rec_t rec_i,
  input  wire logic               pop_i,
  output omr_pkg::cell_rec_t      rec_o,
  output logic                    full_o,
  output logic                    empty_o
);
  import omr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cell_rec_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== rtl/core/omr_back.sv =====
// ----------------------------------------------------------------------------
// omr_back: cell decision engine
// Builds the sheet ID and picks the densest qualifying cell of each question.
// ----------------------------------------------------------------------------
`default_nettype none

module omr_back #(
  parameter int unsigned ID_CELLS = omr_pkg::IdCells
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire omr_pkg::cell_rec_t           rec_i,
  input  wire logic                         q_empty_i,
  output logic                              pop_o,
  input  wire logic [omr_pkg::ChoiceW-1:0]  choices_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              result_kind_o,
  output logic [omr_pkg::IdW-1:0]           sheet_id_o,
  output logic [omr_pkg::ChoiceW-1:0]       choice_o
);
  import omr_pkg::*;

  localparam int unsigned IdCntW = $clog2(ID_CELLS + 1);

  typedef struct packed {
    logic [CountW-1:0] dark;
    logic [CountW-1:0] total;
    logic              clr;
    logic              qual;
    logic              id_bit;
    logic [ProdW-1:0]  prod_new;
    logic [ProdW-1:0]  prod_best;
  } stage_t;

  stage_t             s1_q, s1_d;
  logic               s1_valid_q, s1_valid_d;

  logic [CountW-1:0]  best_dark_q, best_dark_d;
  logic [CountW-1:0]  best_total_q, best_total_d;
  logic [ChoiceW-1:0] best_choice_q, best_choice_d;
  logic [ChoiceW-1:0] ciq_q, ciq_d;
  logic [IdCntW-1:0]  id_done_q, id_done_d;
  logic [IdW-1:0]     id_bits_q, id_bits_d;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [IdW-1:0]     sheet_id_q, sheet_id_d;
  logic [ChoiceW-1:0] choice_q, choice_d;

  logic               out_free, fire;

  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = s1_valid_q && out_free;
  // Take a new cell only once the previous one has updated the best-so-far
  assign pop_o    = !s1_valid_q && !q_empty_i;

  // Stage 1: ratio check and cross products against the current best
  always_comb begin
    s1_d.dark      = rec_i.dark;
    s1_d.total     = rec_i.total;
    s1_d.clr       = rec_i.clr;
    s1_d.qual      = (rec_i.total != '0) &&
                     (RatioW'(rec_i.dark) * DensDen >= RatioW'(rec_i.total) * DensNum);
    s1_d.id_bit    = (rec_i.total != '0) &&
                     ({rec_i.dark, 1'b0} >= {1'b0, rec_i.total});
    s1_d.prod_new  = ProdW'(rec_i.dark) * ProdW'(best_total_q);
    s1_d.prod_best = ProdW'(best_dark_q) * ProdW'(rec_i.total);
    s1_valid_d     = pop_o ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  end

  // Stage 2: apply sheet clear, then update ID or question state
  always_comb begin
    logic [ChoiceW-1:0] bc_eff, ciq_eff, ciq_nx, cpq;
    logic [IdCntW-1:0]  idd_eff;
    logic [IdW-1:0]     idb_eff;
    logic [CountW-1:0]  bd_eff, bt_eff;
    logic               better;

    bd_eff  = s1_q.clr ? '0 : best_dark_q;
    bt_eff  = s1_q.clr ? '0 : best_total_q;
    bc_eff  = s1_q.clr ? '0 : best_choice_q;
    ciq_eff = s1_q.clr ? '0 : ciq_q;
    idd_eff = s1_q.clr ? '0 : id_done_q;
    idb_eff = s1_q.clr ? '0 : id_bits_q;
    cpq     = (choices_i == '0) ? ChoiceW'(1) : choices_i;
    ciq_nx  = ciq_eff + 1'b1;
    better  = (bc_eff == '0) || (s1_q.prod_new > s1_q.prod_best);

    best_dark_d   = best_dark_q;
    best_total_d  = best_total_q;
    best_choice_d = best_choice_q;
    ciq_d         = ciq_q;
    id_done_d     = id_done_q;
    id_bits_d     = id_bits_q;
    out_valid_d   = out_valid_q && out_stall_i;
    kind_d        = kind_q;
    sheet_id_d    = sheet_id_q;
    choice_d      = choice_q;

    if (fire) begin
      best_dark_d   = bd_eff;
      best_total_d  = bt_eff;
      best_choice_d = bc_eff;
      ciq_d         = ciq_eff;
      id_done_d     = idd_eff;
      id_bits_d     = idb_eff;
      if (idd_eff < IdCntW'(ID_CELLS)) begin
        id_bits_d = {idb_eff[IdW-2:0], s1_q.id_bit};
        id_done_d = idd_eff + 1'b1;
        if (idd_eff + 1'b1 == IdCntW'(ID_CELLS)) begin
          out_valid_d = 1'b1;
          kind_d      = KindId;
          sheet_id_d  = {idb_eff[IdW-2:0], s1_q.id_bit};
          choice_d    = '0;
        end
      end else begin
        ciq_d = ciq_nx;
        if (s1_q.qual && better) begin
          best_dark_d   = s1_q.dark;
          best_total_d  = s1_q.total;
          best_choice_d = ciq_nx;
        end
        if (ciq_nx >= cpq) begin
          out_valid_d   = 1'b1;
          kind_d        = KindAnswer;
          sheet_id_d    = '0;
          choice_d      = (s1_q.qual && better) ? ciq_nx : bc_eff;
          best_dark_d   = '0;
          best_total_d  = '0;
          best_choice_d = '0;
          ciq_d         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= s1_d;
    end
    sheet_id_q <= sheet_id_d;
    choice_q   <= choice_d;
    kind_q     <= kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      best_dark_q   <= '0;
      best_total_q  <= '0;
      best_choice_q <= '0;
      ciq_q         <= '0;
      id_done_q     <= '0;
      id_bits_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      best_dark_q   <= best_dark_d;
      best_total_q  <= best_total_d;
      best_choice_q <= best_choice_d;
      ciq_q         <= ciq_d;
      id_done_q     <= id_done_d;
      id_bits_q     <= id_bits_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign sheet_id_o    = sheet_id_q;
  assign choice_o      = choice_q;

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !pop_o) else $error("cell popped over a pending cell");
  a_id_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_done_q <= IdCntW'(ID_CELLS)) else $error("ID cell count past limit");
  a_choice_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_choice_q <= ciq_q) else $error("best choice beyond current cell");
  a_ciq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ciq_q != '1) else $error("question cell count did not wrap");

endmodule

`default_nettype wire

// ===== rtl/core/omr_bubble_mark_reader_top.sv =====
// ----------------------------------------------------------------------------
// omr_bubble_mark_reader_top: answer sheet bubble mark reader
// Pixel stream in, sheet ID and per-question answers out.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock as long as the cells average two or more
// pixels and the output is not stalled. The front counts one pixel per clock
// and drops one cell record per finished cell into a four-entry queue; the
// back takes each cell through two steps (cross products in the first,
// compare and best update in the second) and pops no new cell before the
// last one is done, so a run of one-pixel cells fills the queue and stalls
// the input. A result passes the queue, the stage 1 register and the output
// register, waits behind earlier cells still queued, and is held in the
// output register while stalled. Configuration writes are always ready.
`default_nettype none

module omr_bubble_mark_reader_top #(
  parameter int unsigned ID_CELLS = omr_pkg::IdCells
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [omr_pkg::PixelW-1:0]   pixel_i,
  input  wire logic                         cell_end_i,
  input  wire logic                         sheet_start_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              result_kind_o,
  output logic [omr_pkg::IdW-1:0]           sheet_id_o,
  output logic [omr_pkg::ChoiceW-1:0]       choice_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [omr_pkg::PixelW-1:0]   cfg_data_i
);
  import omr_pkg::*;

  logic [PixelW-1:0]  threshold_q, threshold_d;
  logic [ChoiceW-1:0] choices_q, choices_d;
  logic               q_full, q_empty, push, pop;
  cell_rec_t          rec_in, rec_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    threshold_d = threshold_q;
    choices_d   = choices_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: threshold_d = cfg_data_i;
        CfgChoices:   choices_d   = cfg_data_i[ChoiceW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      choices_q   <= ChoicesReset;
    end else begin
      threshold_q <= threshold_d;
      choices_q   <= choices_d;
    end
  end

  omr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .cell_end_i    (cell_end_i),
    .sheet_start_i (sheet_start_i),
    .threshold_i   (threshold_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .rec_o         (rec_in)
  );

  omr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .rec_o   (rec_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  omr_back #(
    .ID_CELLS (ID_CELLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (rec_out),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .choices_i     (choices_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .sheet_id_o    (sheet_id_o),
    .choice_o      (choice_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_omr_bubble_mark_reader_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_omr_bubble_mark_reader_top: self-checking bench of the bubble mark reader
// Streams pixel items through the reader and keeps its own copy of the cell
// counters, the ID shift register and the best-cell tracking. Each pixel taken
// by the block updates that copy, and every sheet ID or answer that the block
// sends out is compared with the oldest result still due. Directed sheets,
// register extremes, random sheets under varied idling and back-pressure run
// in turn.
// ----------------------------------------------------------------------------

module tb_omr_bubble_mark_reader_top;
  import omr_pkg::*;

  localparam int          SettleCycles = 16;
  localparam int          StallLimit   = 3000;
  localparam logic [1:0]  CfgSpareLo   = 2'd2;
  localparam logic [1:0]  CfgSpareHi   = 2'd3;

  typedef struct packed {
    result_kind_e         kind;
    logic [IdW-1:0]       sheet_id;
    logic [ChoiceW-1:0]   choice;
  } mark_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [PixelW-1:0]   pixel_i       = '0;
  logic                cell_end_i    = 1'b0;
  logic                sheet_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                result_kind_o;
  logic [IdW-1:0]      sheet_id_o;
  logic [ChoiceW-1:0]  choice_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i   = '0;
  logic [PixelW-1:0]   cfg_data_i    = '0;

  // Register copies and sheet state of the reader
  logic [PixelW-1:0]   cfg_thr       = ThresholdReset;
  logic [ChoiceW-1:0]  cfg_choices   = ChoicesReset;
  logic [CountW-1:0]   cell_dark     = '0;
  logic [CountW-1:0]   cell_total    = '0;
  logic [CountW-1:0]   best_dark     = '0;
  logic [CountW-1:0]   best_total    = '0;
  logic [ChoiceW-1:0]  best_choice   = '0;
  logic [ChoiceW-1:0]  cell_in_q     = '0;
  logic [4:0]          id_done       = '0;
  logic [IdW-1:0]      id_shift      = '0;

  mark_result_t        marks_due[$];
  mark_result_t        next_mark;
  mark_result_t        oldest_mark;
  int                  mismatches        = 0;
  int                  pixels_sent       = 0;
  int                  results_predicted = 0;
  int                  send_idle_pct     = 0;
  int                  recv_stall_pct    = 0;
  int                  hold_request      = 0;
  int                  hold_left         = 0;
  int                  quiet_cycles      = 0;

  omr_bubble_mark_reader_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .cell_end_i    (cell_end_i),
    .sheet_start_i (sheet_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .sheet_id_o    (sheet_id_o),
    .choice_o      (choice_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_sheet();
    cell_dark   = '0;
    cell_total  = '0;
    best_dark   = '0;
    best_total  = '0;
    best_choice = '0;
    cell_in_q   = '0;
    id_done     = '0;
    id_shift    = '0;
  endfunction

  // Count one pixel; return 1 when it closes a cell that yields a result
  function automatic bit track_pixel(input logic [PixelW-1:0] pix, input logic cend,
                                     input logic sstart, output mark_result_t res);
    logic [CountW-1:0]  d;
    logic [CountW-1:0]  t;
    logic [ChoiceW-1:0] cpq;
    logic [ProdW-1:0]   lhs;
    logic [ProdW-1:0]   rhs;
    res = '0;
    if (sstart) clear_sheet();
    if (cell_total < CountMax) cell_total++;
    if (pix <= cfg_thr && cell_dark < CountMax) cell_dark++;
    if (!cend) return 1'b0;
    d          = cell_dark;
    t          = cell_total;
    cell_dark  = '0;
    cell_total = '0;
    if (id_done < IdCells) begin
      id_shift = {id_shift[IdW-2:0], (t != 0) && ((ProdW'(d) << 1) >= ProdW'(t))};
      id_done++;
      if (id_done != IdCells) return 1'b0;
      res.kind     = KindId;
      res.sheet_id = id_shift;
      return 1'b1;
    end
    cpq = (cfg_choices == '0) ? ChoiceW'(1) : cfg_choices;
    cell_in_q++;
    lhs = ProdW'(DensDen) * ProdW'(d);
    rhs = ProdW'(DensNum) * ProdW'(t);
    if (t != 0 && lhs >= rhs) begin
      // strictly better only: a tie keeps the earlier cell
      if (best_choice == '0 ||
          ProdW'(d) * ProdW'(best_total) > ProdW'(best_dark) * ProdW'(t)) begin
        best_dark   = d;
        best_total  = t;
        best_choice = cell_in_q;
      end
    end
    if (cell_in_q < cpq) return 1'b0;
    res.kind    = KindAnswer;
    res.choice  = best_choice;
    best_dark   = '0;
    best_total  = '0;
    best_choice = '0;
    cell_in_q   = '0;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (track_pixel(pixel_i, cell_end_i, sheet_start_i, next_mark)) begin
          marks_due.push_back(next_mark);
          results_predicted++;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (marks_due.size() == 0) begin
          $error("result with none due: kind %0d id %h choice %0d",
                 result_kind_o, sheet_id_o, choice_o);
          mismatches++;
        end else begin
          oldest_mark = marks_due.pop_front();
          if (result_kind_o !== oldest_mark.kind) begin
            $error("result_kind: expected %0d, got %0d", oldest_mark.kind, result_kind_o);
            mismatches++;
          end
          if (sheet_id_o !== oldest_mark.sheet_id) begin
            $error("sheet_id: expected %h, got %h", oldest_mark.sheet_id, sheet_id_o);
            mismatches++;
          end
          if (choice_o !== oldest_mark.choice) begin
            $error("choice: expected %0d, got %0d", oldest_mark.choice, choice_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no progress for %0d cycles, %0d results still due", StallLimit, marks_due.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_pixel(input logic [PixelW-1:0] pix, input logic cend,
                            input logic sstart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= pix;
    cell_end_i    <= cend;
    sheet_start_i <= sstart;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Send n_pix pixels as one cell, n_dark dark at random (all at threshold FF)
  task automatic send_cell(input int n_pix, input int n_dark, input bit sstart);
    int                dark_left;
    bit                dark;
    logic [PixelW-1:0] pix;
    dark_left = n_dark;
    for (int i = 0; i < n_pix; i++) begin
      dark = int'($urandom_range(n_pix - i - 1, 0)) < dark_left;
      if (dark) dark_left--;
      if (cfg_thr == 8'hFF) begin
        pix = 8'($urandom);
      end else if (dark) begin
        case ($urandom_range(3))
          0:       pix = '0;
          1:       pix = cfg_thr;
          default: pix = 8'($urandom_range(cfg_thr, 0));
        endcase
      end else begin
        case ($urandom_range(3))
          0:       pix = 8'hFF;
          1:       pix = cfg_thr + 8'd1;
          default: pix = 8'($urandom_range(255, int'(cfg_thr) + 1));
        endcase
      end
      send_pixel(pix, i == n_pix - 1, sstart && i == 0);
    end
  endtask

  // Favor the ratios that sit on a decision boundary
  function automatic int pick_dark(input int n);
    case ($urandom_range(4))
      0:       return 0;
      1:       return n;
      2:       return (n + 1) / 2;
      3:       return (3 * n + 9) / 10;
      default: return $urandom_range(n, 0);
    endcase
  endfunction

  task automatic send_sheet(input bit fresh, input int id_cells, input int questions,
                            input int max_cell);
    int n;
    int cpq;
    bit first;
    first = fresh;
    cpq   = (cfg_choices == '0) ? 1 : cfg_choices;
    for (int c = 0; c < id_cells; c++) begin
      n = $urandom_range(3, 1);
      send_cell(n, pick_dark(n), first);
      first = 1'b0;
    end
    for (int c = 0; c < questions * cpq; c++) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(max_cell, 1) : $urandom_range(6, 1);
      send_cell(n, pick_dark(n), first);
      first = 1'b0;
    end
  endtask

  // Drop valid, wait for every result due, then let the back end finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (marks_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [PixelW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgThreshold) cfg_thr = data;
    else if (idx == CfgChoices) cfg_choices = data[ChoiceW-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_reset_config_sheet();
    send_idle_pct  = 34;
    recv_stall_pct = 86;
    // ID bits from single pixels around the threshold and at the range ends
    send_pixel(8'd200, 1'b1, 1'b1);
    send_pixel(8'd201, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    send_cell(2, 1, 0);
    send_cell(3, 1, 0);
    send_cell(4, 2, 0);
    send_cell(5, 2, 0);
    repeat (8) send_cell(1, $urandom_range(1), 0);
    // exactly 3/10 wins, 2/7 falls short, the later 3/10 ties
    send_cell(10, 3, 0);
    send_cell(7, 2, 0);
    send_cell(10, 3, 0);
    send_cell(4, 1, 0);
    repeat (4) send_cell(4, 1, 0);
    send_cell(2, 1, 0);
    send_cell(1, 1, 0);
    send_cell(1, 1, 0);
    send_cell(3, 3, 0);
    // a sheet start in the middle of a cell drops the partial counts
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_cell(3, 0, 1);
    repeat (15) send_cell(1, $urandom_range(1), 0);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    reg_write(CfgThreshold, 8'd0);
    reg_write(CfgChoices, 8'd1);
    for (int c = 0; c < IdCells; c++) send_pixel(8'(c % 2), 1'b1, c == 0);
    send_pixel(8'd0, 1'b1, 1'b0);
    send_pixel(8'd1, 1'b1, 1'b0);
    send_cell(3, 1, 0);
    wait_idle();
    reg_write(CfgThreshold, 8'hFF);
    reg_write(CfgChoices, 8'd15);
    send_sheet(1, IdCells, 1, 3);
    repeat (5) send_cell(2, 1, 0);
    // shrink the question below the cells already seen: the next cell closes it
    wait_idle();
    reg_write(CfgChoices, 8'd3);
    send_cell(1, 1, 0);
    wait_idle();
    reg_write(CfgChoices, 8'd0);
    send_cell(2, 1, 0);
    send_cell(1, 0, 0);
    wait_idle();
    reg_write(CfgSpareLo, 8'hAA);
    reg_write(CfgSpareHi, 8'h55);
    send_cell(1, 1, 0);
  endtask

  task automatic test_random_sheets(input int send_pct, input int recv_pct,
                                    input int item_goal, input int result_goal);
    int items_from;
    int results_from;
    int max_cell;
    wait_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    case ($urandom_range(5))
      0:       reg_write(CfgThreshold, 8'd0);
      1:       reg_write(CfgThreshold, 8'hFF);
      default: reg_write(CfgThreshold, 8'($urandom_range(230, 30)));
    endcase
    reg_write(CfgChoices, ($urandom_range(4) == 0) ? 8'($urandom_range(15, 7))
                                                   : 8'($urandom_range(6, 1)));
    items_from   = pixels_sent;
    results_from = results_predicted;
    while (pixels_sent - items_from < item_goal ||
           results_predicted - results_from < result_goal) begin
      max_cell = ($urandom_range(7) == 0) ? 40 : 8;
      case ($urandom_range(9))
        0: repeat ($urandom_range(30, 5))
             send_pixel(8'($urandom), $urandom_range(3) == 0, $urandom_range(19) == 0);
        1: send_sheet(1, $urandom_range(IdCells - 1, 1), 0, max_cell);
        2: begin
          send_sheet(1, IdCells, $urandom_range(2), max_cell);
          send_sheet(0, 0, 1, max_cell);
          repeat ($urandom_range(2, 1)) send_cell(2, $urandom_range(2), 0);
        end
        default: send_sheet(1, IdCells, $urandom_range(5, 1), max_cell);
      endcase
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    reg_write(CfgThreshold, 8'd128);
    reg_write(CfgChoices, 8'd1);
    send_sheet(1, IdCells, 0, 1);
    // hold the output while one-pixel cells pile up behind it
    hold_request = 300;
    repeat (24) send_cell(1, $urandom_range(1), 0);
    wait_idle();
    repeat (10) send_cell($urandom_range(2, 1), $urandom_range(2), 0);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config_sheet();
    test_register_extremes();
    test_random_sheets(34, 86, 20, 1);
    test_random_sheets(86, 34, 20, 1);
    test_random_sheets(0, 0, 20, 1);
    test_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/omr_pkg.sv
rtl/core/omr_front.sv
rtl/core/omr_queue.sv
rtl/core/omr_back.sv
rtl/core/omr_bubble_mark_reader_top.sv
dv/tb_omr_bubble_mark_reader_top.sv
